// ===== hdl/ffalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ffalu_pkg
// Shared codes, widths and types of the single-precision four-function ALU.
// ----------------------------------------------------------------------------
package ffalu_pkg;

  // operator character codes
  localparam logic [7:0] CMD_ADD = 8'd43;
  localparam logic [7:0] CMD_SUB = 8'd45;
  localparam logic [7:0] CMD_MUL = 8'd42;
  localparam logic [7:0] CMD_DIV = 8'd47;

  // error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_INF     = 2'd1;
  localparam logic [1:0] ERR_DIVZERO = 2'd2;
  localparam logic [1:0] ERR_BADOP   = 2'd3;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // quotient bits produced by the divider, and bits per divider stage
  localparam int QUO_BITS         = 26;
  localparam int DIV_STEP_DEFAULT = 2;

  // wide mantissa and working exponent
  localparam int MW = 48;
  localparam int EW = 11;

  typedef logic signed [EW-1:0] exp_t;
  typedef logic [MW-1:0]        wide_t;

  // unrounded result: value = m * 2^(e - 174)
  typedef struct packed {
    logic       special;
    logic [1:0] err;
    logic       sign;
    exp_t       e;
    wide_t      m;
  } norm_t;

endpackage

// ===== hdl/ffalu_div.sv =====
// ----------------------------------------------------------------------------
// ffalu_div
// Pipelined restoring divider: quo = floor(num * 2^25 / den), plus sticky.
// ----------------------------------------------------------------------------
module ffalu_div #(
  parameter int DIV_STEP = ffalu_pkg::DIV_STEP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [23:0]                   num,
  input  logic [23:0]                   den,
  output logic [ffalu_pkg::QUO_BITS-1:0] quo,
  output logic                          sticky
);

  localparam int QB     = ffalu_pkg::QUO_BITS;
  localparam int STAGES = QB / DIV_STEP;

  logic [24:0]   rem   [STAGES];
  logic [23:0]   den_p [STAGES];
  logic [QB-1:0] quo_p [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [24:0]   r_in;
    logic [24:0]   r_w;
    logic [23:0]   d_in;
    logic [QB-1:0] q_in;
    logic [QB-1:0] q_w;

    if (k == 0) begin : g_first
      assign r_in = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign d_in = den_p[k-1];
      assign q_in = quo_p[k-1];
    end

    // remainder is kept doubled after each step
    always_comb begin
      r_w = r_in;
      q_w = q_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (r_w >= {1'b0, d_in}) begin
          r_w = (r_w - {1'b0, d_in}) << 1;
          q_w = {q_w[QB-2:0], 1'b1};
        end else begin
          r_w = r_w << 1;
          q_w = {q_w[QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= r_w;
        den_p[k] <= d_in;
        quo_p[k] <= q_w;
      end
    end
  end

  assign quo    = quo_p[STAGES-1];
  assign sticky = |rem[STAGES-1];

endmodule

// ===== hdl/ffalu_round.sv =====
// ----------------------------------------------------------------------------
// ffalu_round
// Normalise, denormalise and round-to-nearest-even; three register stages.
// ----------------------------------------------------------------------------
module ffalu_round (
  input  logic             clk,
  input  logic             en,
  input  ffalu_pkg::norm_t rin,
  output logic [31:0]      answer,
  output logic [1:0]       error_code
);

  typedef struct packed {
    logic       special;
    logic [1:0] err;
    logic       sign;
    logic       zero;
    logic       left;
    logic [5:0] amt;
    logic       ovf;
    logic [7:0] ef;
    ffalu_pkg::wide_t m;
  } r1_t;

  typedef struct packed {
    logic        special;
    logic [1:0]  err;
    logic        sign;
    logic        zero;
    logic        ovf;
    logic [7:0]  ef;
    logic [23:0] mant;
    logic        g;
    logic        st;
  } r2_t;

  function automatic logic [5:0] lzc48(input ffalu_pkg::wide_t v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < ffalu_pkg::MW; i++) begin
      if (v[i]) n = 6'(ffalu_pkg::MW - 1 - i);
    end
    return n;
  endfunction

  r1_t b1, b1_next;
  r2_t b2, b2_next;

  logic [5:0]      lz;
  ffalu_pkg::exp_t lz_s;
  ffalu_pkg::exp_t expf;
  ffalu_pkg::exp_t rsh;

  always_comb begin
    lz   = lzc48(rin.m);
    lz_s = ffalu_pkg::exp_t'({5'b0, lz});
    rsh  = ffalu_pkg::exp_t'(1) - rin.e;
    b1_next.special = rin.special;
    b1_next.err     = rin.err;
    b1_next.sign    = rin.sign;
    b1_next.zero    = (rin.m == '0);
    b1_next.m       = rin.m;
    if (rin.e > lz_s) begin
      b1_next.left = 1'b1;
      b1_next.amt  = lz;
      expf         = rin.e - lz_s;
    end else if (rin.e >= ffalu_pkg::exp_t'(1)) begin
      // subnormal: shift only as far as the minimum exponent
      b1_next.left = 1'b1;
      b1_next.amt  = 6'(rin.e - ffalu_pkg::exp_t'(1));
      expf         = '0;
    end else begin
      b1_next.left = 1'b0;
      b1_next.amt  = (rsh > ffalu_pkg::exp_t'(63)) ? 6'd63 : rsh[5:0];
      expf         = '0;
    end
    b1_next.ovf = (expf >= ffalu_pkg::exp_t'(255));
    b1_next.ef  = expf[7:0];
  end

  ffalu_pkg::wide_t m2;
  logic             rs;

  always_comb begin
    if (b1.left) begin
      m2 = b1.m << b1.amt;
      rs = 1'b0;
    end else begin
      m2 = b1.m >> b1.amt;
      rs = |(b1.m & ~({ffalu_pkg::MW{1'b1}} << b1.amt));
    end
    b2_next.special = b1.special;
    b2_next.err     = b1.err;
    b2_next.sign    = b1.sign;
    b2_next.zero    = b1.zero;
    b2_next.ovf     = b1.ovf;
    b2_next.ef      = b1.ef;
    b2_next.mant    = m2[47:24];
    b2_next.g       = m2[23];
    b2_next.st      = (|m2[22:0]) | rs;
  end

  logic        up;
  logic [30:0] mag;

  // carry out of the fraction moves into the exponent, up to infinity
  assign up  = b2.g & (b2.st | b2.mant[0]);
  assign mag = {b2.ef, b2.mant[22:0]} + 31'(up);

  always_ff @(posedge clk) begin
    if (en) begin
      b1 <= b1_next;
      b2 <= b2_next;
      error_code <= b2.err;
      if (b2.special) begin
        answer <= ffalu_pkg::QNAN;
      end else if (b2.zero) begin
        answer <= {b2.sign, 31'b0};
      end else if (b2.ovf) begin
        answer <= {b2.sign, 8'hFF, 23'b0};
      end else begin
        answer <= {b2.sign, mag};
      end
    end
  end

endmodule

// ===== hdl/float_four_function_alu_core.sv =====
// Throughput: one item per cycle for every operator while the output is not stalled;
// the divider stages set the depth and add, subtract and multiply ride a delay line
// alongside them.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears only the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// float_four_function_alu_core
// Pipelined single-precision add, subtract, multiply and divide with error codes.
// ----------------------------------------------------------------------------
module float_four_function_alu_core #(
  parameter int DIV_STEP = ffalu_pkg::DIV_STEP_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  cmd,
  input  logic [31:0] first_operand,
  input  logic [31:0] second_operand,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] answer,
  output logic [1:0]  error_code
);

  localparam int DIV_STAGES = ffalu_pkg::QUO_BITS / DIV_STEP;
  localparam int DLY        = DIV_STAGES - 3;
  localparam int LAT        = DIV_STAGES + 5;
  localparam int PAD        = ffalu_pkg::MW - ffalu_pkg::QUO_BITS - 1;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_MUL = 2'd1;
  localparam logic [1:0] KIND_DIV = 2'd2;

  typedef struct packed {
    logic            special;
    logic [1:0]      err;
    logic [1:0]      kind;
    logic            effsub;
    logic            sa;
    logic            sb;
    ffalu_pkg::exp_t ea;
    ffalu_pkg::exp_t eb;
    logic [23:0]     ma;
    logic [23:0]     mb;
    logic [4:0]      lza;
    logic [4:0]      lzb;
  } dec_t;

  typedef struct packed {
    logic            special;
    logic [1:0]      err;
    logic [1:0]      kind;
    logic            effsub;
    logic            sa;
    logic            sb;
    ffalu_pkg::exp_t ea;
    ffalu_pkg::exp_t eb;
    logic [23:0]     ma;
    logic [23:0]     mb;
  } nrm_t;

  typedef struct packed {
    logic             special;
    logic [1:0]       err;
    logic [1:0]       kind;
    logic             effsub;
    logic             sign;
    ffalu_pkg::exp_t  e;
    logic [23:0]      ml;
    logic [23:0]      ms;
    logic [8:0]       gap;
    ffalu_pkg::wide_t prod;
  } st3_t;

  typedef struct packed {
    logic             special;
    logic [1:0]       err;
    logic [1:0]       kind;
    logic             effsub;
    logic             sign;
    ffalu_pkg::exp_t  e;
    ffalu_pkg::wide_t lf;
    ffalu_pkg::wide_t sf;
  } st4_t;

  typedef struct packed {
    logic             is_div;
    ffalu_pkg::norm_t n;
  } item_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // pipeline control
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv          = !(vld[LAT-1] && result_stall);
  assign stall        = !adv;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], valid};
    end
  end

  // stage 1: decode and classify
  dec_t        d1, d1_next;
  logic [30:0] fa, fb;
  logic        inf_any, nan_any, op_ok, is_sub;
  logic [7:0]  xa, xb;

  assign fa = first_operand[30:0];
  assign fb = second_operand[30:0];
  assign xa = first_operand[30:23];
  assign xb = second_operand[30:23];

  always_comb begin
    inf_any = (fa == 31'h7F80_0000) || (fb == 31'h7F80_0000);
    nan_any = (fa > 31'h7F80_0000) || (fb > 31'h7F80_0000);
    is_sub  = (cmd == ffalu_pkg::CMD_SUB);
    op_ok   = (cmd == ffalu_pkg::CMD_ADD) || is_sub ||
              (cmd == ffalu_pkg::CMD_MUL) || (cmd == ffalu_pkg::CMD_DIV);
    if (inf_any) begin
      d1_next.err = ffalu_pkg::ERR_INF;
    end else if (!op_ok) begin
      d1_next.err = ffalu_pkg::ERR_BADOP;
    end else if ((cmd == ffalu_pkg::CMD_DIV) && (fb == 31'd0)) begin
      d1_next.err = ffalu_pkg::ERR_DIVZERO;
    end else begin
      d1_next.err = ffalu_pkg::ERR_OK;
    end
    d1_next.special = (d1_next.err != ffalu_pkg::ERR_OK) || nan_any;
    if (cmd == ffalu_pkg::CMD_MUL) begin
      d1_next.kind = KIND_MUL;
    end else if (cmd == ffalu_pkg::CMD_DIV) begin
      d1_next.kind = KIND_DIV;
    end else begin
      d1_next.kind = KIND_ADD;
    end
    d1_next.sa     = first_operand[31];
    d1_next.sb     = second_operand[31];
    d1_next.effsub = first_operand[31] ^ second_operand[31] ^ is_sub;
    d1_next.ea     = (xa == 8'd0) ? ffalu_pkg::exp_t'(1) : ffalu_pkg::exp_t'({3'b000, xa});
    d1_next.eb     = (xb == 8'd0) ? ffalu_pkg::exp_t'(1) : ffalu_pkg::exp_t'({3'b000, xb});
    d1_next.ma     = {xa != 8'd0, first_operand[22:0]};
    d1_next.mb     = {xb != 8'd0, second_operand[22:0]};
    d1_next.lza    = lzc24(d1_next.ma);
    d1_next.lzb    = lzc24(d1_next.mb);
  end

  // stage 2: normalise subnormal operands
  nrm_t n2, n2_next;

  always_comb begin
    n2_next.special = d1.special;
    n2_next.err     = d1.err;
    n2_next.kind    = d1.kind;
    n2_next.effsub  = d1.effsub;
    n2_next.sa      = d1.sa;
    n2_next.sb      = d1.sb;
    n2_next.ma      = d1.ma << d1.lza;
    n2_next.mb      = d1.mb << d1.lzb;
    n2_next.ea      = d1.ea - $signed({6'b0, d1.lza});
    n2_next.eb      = d1.eb - $signed({6'b0, d1.lzb});
  end

  // stage 3: product, or magnitude compare and swap
  st3_t            s3, s3_next;
  logic            big;
  ffalu_pkg::exp_t diff;

  always_comb begin
    big  = (n2.ea > n2.eb) || ((n2.ea == n2.eb) && (n2.ma >= n2.mb));
    diff = big ? (n2.ea - n2.eb) : (n2.eb - n2.ea);
    s3_next.special = n2.special;
    s3_next.err     = n2.err;
    s3_next.kind    = n2.kind;
    s3_next.effsub  = n2.effsub;
    s3_next.ml      = big ? n2.ma : n2.mb;
    s3_next.ms      = big ? n2.mb : n2.ma;
    s3_next.gap     = diff[8:0];
    s3_next.prod    = n2.ma * n2.mb;
    case (n2.kind)
      KIND_ADD: begin
        s3_next.sign = big ? n2.sa : (n2.sa ^ n2.effsub);
        s3_next.e    = (big ? n2.ea : n2.eb) + ffalu_pkg::exp_t'(1);
      end
      KIND_MUL: begin
        s3_next.sign = n2.sa ^ n2.sb;
        s3_next.e    = n2.ea + n2.eb - ffalu_pkg::exp_t'(126);
      end
      default: begin
        s3_next.sign = n2.sa ^ n2.sb;
        s3_next.e    = n2.ea - n2.eb + ffalu_pkg::exp_t'(127);
      end
    endcase
  end

  // stage 4: align the smaller addend, sticky into bit 0
  st4_t             s4, s4_next;
  ffalu_pkg::wide_t sf_raw, sf_sh;
  logic             sf_st;

  always_comb begin
    sf_raw = {1'b0, s3.ms, 23'b0};
    sf_sh  = sf_raw >> s3.gap;
    sf_st  = |(sf_raw & ~({ffalu_pkg::MW{1'b1}} << s3.gap));
    s4_next.special = s3.special;
    s4_next.err     = s3.err;
    s4_next.kind    = s3.kind;
    s4_next.effsub  = s3.effsub;
    s4_next.sign    = s3.sign;
    s4_next.e       = s3.e;
    s4_next.lf      = (s3.kind == KIND_MUL) ? s3.prod : {1'b0, s3.ml, 23'b0};
    s4_next.sf      = {sf_sh[ffalu_pkg::MW-1:1], sf_sh[0] | sf_st};
  end

  // stage 5: add or subtract, then the delay line that matches the divider
  item_t            s5_next;
  item_t            dly [DLY+1];
  ffalu_pkg::wide_t sum;

  always_comb begin
    sum = s4.effsub ? (s4.lf - s4.sf) : (s4.lf + s4.sf);
    s5_next.is_div    = (s4.kind == KIND_DIV);
    s5_next.n.special = s4.special;
    s5_next.n.err     = s4.err;
    s5_next.n.e       = s4.e;
    s5_next.n.m       = (s4.kind == KIND_ADD) ? sum : s4.lf;
    // exact cancellation gives +0
    s5_next.n.sign    = ((s4.kind == KIND_ADD) && s4.effsub && (sum == '0)) ? 1'b0
                                                                             : s4.sign;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1     <= d1_next;
      n2     <= n2_next;
      s3     <= s3_next;
      s4     <= s4_next;
      dly[0] <= s5_next;
      for (int i = 1; i <= DLY; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // divider runs beside stages 3 onwards
  logic [ffalu_pkg::QUO_BITS-1:0] quo;
  logic                           quo_st;

  ffalu_div #(
    .DIV_STEP(DIV_STEP)
  ) u_div (
    .clk   (clk),
    .en    (adv),
    .num   (n2.ma),
    .den   (n2.mb),
    .quo   (quo),
    .sticky(quo_st)
  );

  ffalu_pkg::norm_t rin;

  always_comb begin
    rin = dly[DLY].n;
    if (dly[DLY].is_div) begin
      rin.m = {quo, {PAD{1'b0}}, quo_st};
    end
  end

  ffalu_round u_round (
    .clk       (clk),
    .en        (adv),
    .rin       (rin),
    .answer    (answer),
    .error_code(error_code)
  );

endmodule

// ===== hdl/ffalu_chk.sv =====
// ----------------------------------------------------------------------------
// ffalu_chk
// Port-level checks on the ALU core, attached by bind.
// ----------------------------------------------------------------------------
module ffalu_chk (
  input logic        clk,
  input logic        rst,
  input logic        stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] answer,
  input logic [1:0]  error_code
);

  // nothing comes out in the cycle after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // any error returns the quiet NaN
  a_err_nan: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (error_code != ffalu_pkg::ERR_OK)) |-> (answer == ffalu_pkg::QNAN))
    else $error("error item without quiet NaN");

  // a held result backs up into the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> stall)
    else $error("input not stalled while result held");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(answer) && $stable(error_code)))
    else $error("stalled result changed");

endmodule

bind float_four_function_alu_core ffalu_chk u_ffalu_chk (.*);
